// ===== src/full_linear_convolution_assert.svh =====
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef FULL_LINEAR_CONVOLUTION_ASSERT_SVH
`define FULL_LINEAR_CONVOLUTION_ASSERT_SVH

// Same-cycle implication.
`define FLC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/flc_pkg.sv =====
package flc_pkg;

    localparam int DATA_W       = 16;
    localparam int PROD_W       = 2 * DATA_W;
    localparam int GROUP        = 8;
    localparam int GSUM_W       = PROD_W + 3;
    localparam int OUT_W        = 38;
    localparam int OUT_TDATA_W  = 40;
    localparam int IDX_W        = 6;
    localparam int IN_TDATA_W   = 24;
    localparam int TC_W         = 7;
    localparam int CNT_W        = 9;
    localparam int MAX_TAPS_DEF = 64;

    localparam logic FUNC_TAP    = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

// ===== src/flc_cell.sv =====
module flc_cell (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  flc_pkg::cell_ctrl_t                       ctrl,
    input  logic                                      active,
    input  logic                                      tap_we,
    input  logic signed [flc_pkg::DATA_W-1:0]         tap_wdata,
    input  logic signed [flc_pkg::DATA_W-1:0]         sample_in,
    output logic signed [flc_pkg::DATA_W-1:0]         sample_out,
    output logic signed [flc_pkg::PROD_W-1:0]         product
);

    logic signed [flc_pkg::DATA_W-1:0] tap_reg;
    logic signed [flc_pkg::DATA_W-1:0] hist_reg;
    logic signed [flc_pkg::PROD_W-1:0] prod_reg;
    logic signed [flc_pkg::PROD_W-1:0] prod_next;

    // product uses the sample that is shifted in on this step
    always_comb
    begin
        if (active)
        begin
            prod_next = tap_reg * sample_in;
        end
        else
        begin
            prod_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg  <= '0;
            hist_reg <= '0;
        end
        else
        begin
            if (tap_we)
            begin
                tap_reg <= tap_wdata;
            end
            if (ctrl.shift)
            begin
                hist_reg <= ctrl.clear ? '0 : sample_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            prod_reg <= prod_next;
        end
    end

    assign sample_out = hist_reg;
    assign product    = prod_reg;

endmodule

// ===== src/flc_group_sum.sv =====
module flc_group_sum (
    input  logic                                      clk,
    input  logic                                      en,
    input  logic signed [flc_pkg::PROD_W-1:0]         prod [flc_pkg::GROUP],
    output logic signed [flc_pkg::GSUM_W-1:0]         sum
);

    logic signed [flc_pkg::GSUM_W-1:0] sum_reg;
    logic signed [flc_pkg::GSUM_W-1:0] sum_next;

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < flc_pkg::GROUP; k++)
        begin
            sum_next = sum_next + flc_pkg::GSUM_W'(prod[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

// ===== src/full_linear_convolution.sv =====
// Each sample's products, group sums and output value are registered in turn.
// Throughput: one request per cycle, taps and samples alike, unless the output stalls;
// a last sample holds off input as n-1 zeros flush, n being tap_count clamped to 1..MAX_TAPS.
// Tap writes take no output slot. A stalled output backs up through the pipeline.
// Reset (rst_n, async, active low): taps and delay line cleared, tap_count = 1,
// pipeline and output empty.
module full_linear_convolution #(
    parameter int MAX_TAPS = flc_pkg::MAX_TAPS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [flc_pkg::TC_W-1:0]            cfg_wdata,      // tap_count
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [flc_pkg::IN_TDATA_W-1:0]      s_tdata,        // [5:0] tap_index, [21:6] value
    input  logic [0:0]                          s_tuser,        // [0] func
    input  logic                                s_tlast,        // last_sample
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [flc_pkg::OUT_TDATA_W-1:0]     m_tdata,        // [37:0] out_value
    output logic                                m_tlast         // out_last
);

    localparam int NGROUPS = (MAX_TAPS + flc_pkg::GROUP - 1) / flc_pkg::GROUP;
    localparam int NPAD    = NGROUPS * flc_pkg::GROUP;
    localparam int CW      = flc_pkg::CNT_W;

    logic [flc_pkg::TC_W-1:0]  tap_count_reg;
    logic [CW-1:0]             tc_ext;
    logic [CW-1:0]             n_eff;

    logic                      flushing_reg;
    logic [CW-1:0]             flush_left_reg;

    logic                      v1_reg, last1_reg;
    logic                      v2_reg, last2_reg;
    logic                      out_valid_reg, out_last_reg;
    logic signed [flc_pkg::OUT_W-1:0] out_value_reg;
    logic signed [flc_pkg::OUT_W-1:0] total;

    logic                      en_out, en2, en1;
    logic                      accept, sample_acc, tap_wr;
    logic                      issue, issue_final;
    logic [flc_pkg::IDX_W-1:0] in_idx;
    logic signed [flc_pkg::DATA_W-1:0] in_value;
    logic signed [flc_pkg::DATA_W-1:0] feed;
    flc_pkg::cell_ctrl_t       ctrl;

    logic signed [flc_pkg::DATA_W-1:0] hist [MAX_TAPS];
    logic signed [flc_pkg::PROD_W-1:0] prod [NPAD];
    logic signed [flc_pkg::GSUM_W-1:0] gsum [NGROUPS];

    assign in_idx   = s_tdata[flc_pkg::IDX_W-1:0];
    assign in_value = $signed(s_tdata[flc_pkg::IDX_W +: flc_pkg::DATA_W]);

    // zero acts as one, anything past the table acts as the full table
    assign tc_ext = {{(CW - flc_pkg::TC_W){1'b0}}, tap_count_reg};
    always_comb
    begin
        if (tc_ext == '0)
        begin
            n_eff = CW'(1);
        end
        else if (tc_ext > CW'(MAX_TAPS))
        begin
            n_eff = CW'(MAX_TAPS);
        end
        else
        begin
            n_eff = tc_ext;
        end
    end

    // pipeline advance, back to front
    assign en_out = !out_valid_reg || m_tready;
    assign en2    = !v2_reg || en_out;
    assign en1    = !v1_reg || en2;

    assign s_tready   = en1 && !flushing_reg;
    assign accept     = s_tvalid && s_tready;
    assign sample_acc = accept && (s_tuser[0] == flc_pkg::FUNC_SAMPLE);
    assign tap_wr     = accept && (s_tuser[0] == flc_pkg::FUNC_TAP);

    assign issue       = sample_acc || (flushing_reg && en1);
    assign issue_final = (sample_acc && s_tlast && (n_eff == CW'(1)))
                       || (flushing_reg && en1 && (flush_left_reg == CW'(1)));
    assign feed        = flushing_reg ? '0 : in_value;

    assign ctrl.shift = issue;
    assign ctrl.clear = issue_final;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= flc_pkg::TC_W'(1);
        end
        else if (cfg_we)
        begin
            tap_count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flushing_reg   <= 1'b0;
            flush_left_reg <= '0;
        end
        else if (sample_acc && s_tlast && (n_eff != CW'(1)))
        begin
            flushing_reg   <= 1'b1;
            flush_left_reg <= n_eff - CW'(1);
        end
        else if (flushing_reg && en1)
        begin
            flush_left_reg <= flush_left_reg - CW'(1);
            if (flush_left_reg == CW'(1))
            begin
                flushing_reg <= 1'b0;
            end
        end
    end

    genvar j;
    generate
        for (j = 0; j < MAX_TAPS; j++)
        begin : g_cell
            logic signed [flc_pkg::DATA_W-1:0] cell_in;
            logic                              cell_we;
            logic                              cell_active;

            if (j == 0)
            begin : g_head
                assign cell_in = feed;
            end
            else
            begin : g_body
                assign cell_in = hist[j-1];
            end

            assign cell_we = tap_wr
                && ({{(CW - flc_pkg::IDX_W){1'b0}}, in_idx} == CW'(j));
            assign cell_active = CW'(j) < n_eff;

            flc_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .active     (cell_active),
                .tap_we     (cell_we),
                .tap_wdata  (in_value),
                .sample_in  (cell_in),
                .sample_out (hist[j]),
                .product    (prod[j])
            );
        end

        for (j = MAX_TAPS; j < NPAD; j++)
        begin : g_pad
            assign prod[j] = '0;
        end

        for (j = 0; j < NGROUPS; j++)
        begin : g_group
            logic signed [flc_pkg::PROD_W-1:0] gp [flc_pkg::GROUP];

            for (genvar k = 0; k < flc_pkg::GROUP; k++)
            begin : g_tap
                assign gp[k] = prod[j * flc_pkg::GROUP + k];
            end

            flc_group_sum u_group (
                .clk  (clk),
                .en   (en2),
                .prod (gp),
                .sum  (gsum[j])
            );
        end
    endgenerate

    // wraps modulo 2^OUT_W
    always_comb
    begin
        total = '0;
        for (int g = 0; g < NGROUPS; g++)
        begin
            total = total + flc_pkg::OUT_W'(gsum[g]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            last1_reg     <= 1'b0;
            v2_reg        <= 1'b0;
            last2_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg    <= issue;
                last1_reg <= issue_final;
            end
            if (en2)
            begin
                v2_reg    <= v1_reg;
                last2_reg <= last1_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= v2_reg;
                out_last_reg  <= last2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            out_value_reg <= total;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(flc_pkg::OUT_TDATA_W - flc_pkg::OUT_W){1'b0}}, out_value_reg};

`include "full_linear_convolution_assert.svh"

    `FLC_ASSERT_NEXT(a_flush_start, sample_acc && s_tlast && (n_eff != CW'(1)), flushing_reg, "last sample did not start the tail flush")
    `FLC_ASSERT_NOW(a_flush_count, flushing_reg, flush_left_reg != '0, "flush running with no zeros left")
    `FLC_ASSERT_NEXT(a_flush_issue, flushing_reg && en1, v1_reg, "flush step did not issue a zero sample")
    `FLC_ASSERT_NEXT(a_hist_clear, issue_final, hist[0] == '0, "delay line not cleared after final output")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int   TAPS         = flc_pkg::MAX_TAPS_DEF;
    localparam int   OUT_W        = flc_pkg::OUT_W;
    localparam int   TC_W         = flc_pkg::TC_W;
    localparam int   IDX_W        = flc_pkg::IDX_W;
    localparam int   IN_TDATA_W   = flc_pkg::IN_TDATA_W;
    localparam int   OUT_TDATA_W  = flc_pkg::OUT_TDATA_W;
    localparam logic FUNC_TAP     = flc_pkg::FUNC_TAP;
    localparam logic FUNC_SAMPLE  = flc_pkg::FUNC_SAMPLE;

    localparam int ITEM_TARGET  = 520;
    localparam int QUIET_START  = 420;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic             last;
    } conv_result_t;

    typedef struct packed {
        logic             is_cfg;
        logic [TC_W-1:0]  cfg_val;
        logic             func;
        logic [IDX_W-1:0] idx;
        logic [15:0]      value;
        logic             last;
        logic             has_exp;
        logic [OUT_W-1:0] exp_val;
        logic             exp_last;
    } stim_row_t;

    // is_cfg, cfg_val, func, idx, value, last, has_exp, exp_val, exp_last
    localparam int DIRECTED_ROWS = 27;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{1'b0, 7'd0,   FUNC_SAMPLE, 6'd0,  16'h7FFF, 1'b0, 1'b1, 38'h0, 1'b0},
        '{1'b0, 7'd0,   FUNC_TAP,    6'd0,  16'h8000, 1'b0, 1'b0, 38'h0, 1'b0},
        '{1'b0, 7'd0,   FUNC_SAMPLE, 6'd0,  16'h8000, 1'b0, 1'b1, 38'h00_4000_0000, 1'b0},
        '{1'b0, 7'd0,   FUNC_SAMPLE, 6'd0,  16'h7FFF, 1'b0, 1'b1, 38'h3F_C000_8000, 1'b0},
        '{1'b0, 7'd0,   FUNC_TAP,    6'd63, 16'h7FFF, 1'b1, 1'b0, 38'h0, 1'b0},
        '{1'b0, 7'd0,   FUNC_SAMPLE, 6'd5,  16'h0001, 1'b1, 1'b1, 38'h3F_FFFF_8000, 1'b1},
        '{1'b1, 7'd0,   FUNC_TAP,    6'd0,  16'h0000, 1'b0, 1'b0, 38'h0, 1'b0},
        '{1'b0, 7'd0,   FUNC_SAMPLE, 6'd0,  16'h8000, 1'b1, 1'b1, 38'h00_4000_0000, 1'b1},
        '{1'b1, 7'd127, FUNC_TAP,    6'd0,  16'h0000, 1'b0, 1'b0, 38'h0, 1'b0},
        '{1'b0, 7'd0,   FUNC_SAMPLE, 6'd0,  16'h7FFF, 1'b1, 1'b0, 38'h0, 1'b0},
        '{1'b1, 7'd65,  FUNC_TAP,    6'd0,  16'h0000, 1'b0, 1'b0, 38'h0, 1'b0},
        '{1'b0, 7'd0,   FUNC_SAMPLE, 6'd0,  16'h8000, 1'b1, 1'b0, 38'h0, 1'b0},
        '{1'b1, 7'd64,  FUNC_TAP,    6'd0,  16'h0000, 1'b0, 1'b0, 38'h0, 1'b0},
        '{1'b0, 7'd0,   FUNC_TAP,    6'd1,  16'h7FFF, 1'b0, 1'b0, 38'h0, 1'b0},
        '{1'b0, 7'd0,   FUNC_TAP,    6'd62, 16'h8000, 1'b0, 1'b0, 38'h0, 1'b0},
        '{1'b0, 7'd0,   FUNC_SAMPLE, 6'd0,  16'h7FFF, 1'b0, 1'b0, 38'h0, 1'b0},
        '{1'b0, 7'd0,   FUNC_SAMPLE, 6'd0,  16'h8000, 1'b0, 1'b0, 38'h0, 1'b0},
        '{1'b0, 7'd0,   FUNC_SAMPLE, 6'd0,  16'h0000, 1'b1, 1'b0, 38'h0, 1'b0},
        '{1'b1, 7'd2,   FUNC_TAP,    6'd0,  16'h0000, 1'b0, 1'b0, 38'h0, 1'b0},
        '{1'b0, 7'd0,   FUNC_TAP,    6'd1,  16'hFFFF, 1'b0, 1'b0, 38'h0, 1'b0},
        '{1'b0, 7'd0,   FUNC_SAMPLE, 6'd0,  16'h1234, 1'b0, 1'b0, 38'h0, 1'b0},
        '{1'b0, 7'd0,   FUNC_TAP,    6'd0,  16'h0003, 1'b0, 1'b0, 38'h0, 1'b0},
        '{1'b0, 7'd0,   FUNC_SAMPLE, 6'd0,  16'hFEDC, 1'b1, 1'b0, 38'h0, 1'b0},
        '{1'b1, 7'd3,   FUNC_TAP,    6'd0,  16'h0000, 1'b0, 1'b0, 38'h0, 1'b0},
        '{1'b0, 7'd0,   FUNC_TAP,    6'd2,  16'h4000, 1'b0, 1'b0, 38'h0, 1'b0},
        '{1'b0, 7'd0,   FUNC_SAMPLE, 6'd0,  16'h8000, 1'b0, 1'b0, 38'h0, 1'b0},
        '{1'b0, 7'd0,   FUNC_SAMPLE, 6'd0,  16'h7FFF, 1'b1, 1'b0, 38'h0, 1'b0}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [TC_W-1:0]        cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [0:0]             s_tuser = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b1;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    full_linear_convolution dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    // Filter model state
    logic signed [15:0] coef_table [TAPS];
    logic signed [15:0] delay_line [TAPS];
    logic [TC_W-1:0]    tap_count_model = 7'd1;
    conv_result_t       conv_expected [$];

    int  mismatches     = 0;
    int  results_seen   = 0;
    int  items_sent     = 0;
    int  samples_sent   = 0;
    int  taps_sent      = 0;
    int  flushes        = 0;
    int  cfg_writes     = 0;
    int  sender_idle_odds = 2;
    int  pressure_left  = 0;
    bit  quiet_tail     = 1'b0;
    bit  hold_req       = 1'b0;
    bit  hold_done      = 1'b0;

    initial
    begin
        for (int j = 0; j < TAPS; j++)
        begin
            coef_table[j] = '0;
            delay_line[j] = '0;
        end
    end

    function automatic int active_taps();
        if (tap_count_model == 0)
            return 1;
        if (tap_count_model > TAPS)
            return TAPS;
        return int'(tap_count_model);
    endfunction

    function automatic logic [OUT_W-1:0] shift_and_accumulate(logic signed [15:0] x);
        longint acc;
        int     n;
        n = active_taps();
        for (int j = TAPS - 1; j > 0; j--)
            delay_line[j] = delay_line[j-1];
        delay_line[0] = x;
        acc = 0;
        for (int j = 0; j < n; j++)
            acc += longint'(coef_table[j]) * longint'(delay_line[j]);
        return acc[OUT_W-1:0];
    endfunction

    task automatic predict_request(logic func, logic [IDX_W-1:0] idx, logic [15:0] value,
                                   logic last);
        int           n;
        int           count;
        conv_result_t r;
        if (func == FUNC_TAP)
        begin
            coef_table[idx] = value;
            taps_sent++;
            return;
        end
        samples_sent++;
        n = active_taps();
        count = last ? n : 1;
        // Flush the tail with zeros after the sequence's final sample
        for (int k = 0; k < count; k++)
        begin
            r.value = shift_and_accumulate(k == 0 ? value : 16'h0000);
            r.last  = last && (k == count - 1);
            conv_expected.push_back(r);
        end
        if (last)
        begin
            for (int j = 0; j < TAPS; j++)
                delay_line[j] = '0;
            flushes++;
        end
    endtask

    task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
        $display("error: %s at result %0d: got %h, want %h", what, results_seen, got, want);
        mismatches++;
    endtask

    task automatic check_result();
        conv_result_t want;
        if (conv_expected.size() == 0)
        begin
            report_mismatch("result with nothing pending", m_tdata[OUT_W-1:0], '0);
            return;
        end
        want = conv_expected.pop_front();
        results_seen++;
        if (m_tdata[OUT_W-1:0] !== want.value)
            report_mismatch("out_value", m_tdata[OUT_W-1:0], want.value);
        if (m_tlast !== want.last)
            report_mismatch("out_last", {37'b0, m_tlast}, {37'b0, want.last});
    endtask

    task automatic drive_request(logic func, logic [IDX_W-1:0] idx, logic [15:0] value,
                                 logic last);
        if (!quiet_tail && pressure_left == 0 && sender_idle_odds != 0
            && $urandom_range(0, 3 * sender_idle_odds) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        if (pressure_left > 0)
            pressure_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, value, idx};
        s_tuser  <= func;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_request(func, idx, value, last);
        items_sent++;
    endtask

    task automatic write_tap_count(logic [TC_W-1:0] v);
        s_tvalid <= 1'b0;
        while (conv_expected.size() != 0)
            @(posedge clk);
        // Let any tap write still in the pipeline settle
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        tap_count_model = v;
        cfg_writes++;
    endtask

    function automatic logic [15:0] pick_value();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0: v = 16'h8000;
            1: v = 16'h7FFF;
            2: v = 16'h0000;
            3: v = 16'hFFFF;
            default: v = 16'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    function automatic logic [TC_W-1:0] pick_tap_count();
        logic [TC_W-1:0] tc;
        case ($urandom_range(0, 19))
            0: tc = 7'd0;
            1: tc = 7'd64;
            2: tc = 7'($urandom_range(63, 127));
            3: tc = 7'd1;
            default: tc = 7'($urandom_range(2, 8));
        endcase
        return tc;
    endfunction

    // Receiver: check results and stall in random bursts
    initial
    begin
        int stall_left = 0;
        int mode_left = 0;
        int stall_odds = 2;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_result();
            if (mode_left == 0)
            begin
                mode_left = 200;
                stall_odds = $urandom_range(0, 3);
            end
            mode_left--;
            if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    m_tready <= 1'b1;
            end
            else if (hold_req && !hold_done)
            begin
                // Hold off long enough for the pipeline to back up into the input
                hold_done = 1'b1;
                stall_left = 400;
                m_tready <= 1'b0;
            end
            else if (!quiet_tail && stall_odds != 0
                     && $urandom_range(0, 4 * stall_odds) == 0)
            begin
                stall_left = $urandom_range(1, 17);
                m_tready <= 1'b0;
            end
        end
    end

    initial
    begin
        int               n;
        int               len;
        logic [TC_W-1:0]  tc;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (DIRECTED[i].is_cfg)
                write_tap_count(DIRECTED[i].cfg_val);
            else
            begin
                drive_request(DIRECTED[i].func, DIRECTED[i].idx, DIRECTED[i].value,
                              DIRECTED[i].last);
                if (DIRECTED[i].has_exp)
                begin
                    void'(conv_expected.pop_back());
                    conv_expected.push_back('{DIRECTED[i].exp_val, DIRECTED[i].exp_last});
                end
            end
        end

        while (items_sent < ITEM_TARGET)
        begin
            quiet_tail = (items_sent >= QUIET_START);
            if (!quiet_tail)
            begin
                tc = pick_tap_count();
                write_tap_count(tc);
            end
            if (!hold_req)
            begin
                // Stall the receiver while requests keep coming
                hold_req = 1'b1;
                pressure_left = 60;
            end
            n = active_taps();
            sender_idle_odds = $urandom_range(0, 3);
            // Load a full filter first in most phases
            if ($urandom_range(0, 3) != 0)
                for (int j = 0; j < n; j++)
                    drive_request(FUNC_TAP, 6'(j), pick_value(), 1'($urandom_range(0, 1)));
            len = $urandom_range(4, 30);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 6) == 0)
                    drive_request(FUNC_TAP, 6'($urandom_range(0, 63)), pick_value(),
                                  1'($urandom_range(0, 1)));
                else
                    drive_request(FUNC_SAMPLE, 6'($urandom_range(0, 63)), pick_value(),
                                  $urandom_range(0, 9) == 0);
            end
            if ($urandom_range(0, 4) != 0)
                drive_request(FUNC_SAMPLE, 6'($urandom_range(0, 63)), pick_value(), 1'b1);
        end

        quiet_tail = 1'b1;
        s_tvalid <= 1'b0;
        while (conv_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("run covered %0d samples and %0d tap writes over %0d tap_count settings",
                 samples_sent, taps_sent, cfg_writes);
        $display("checked %0d outputs across %0d flushed sequences", results_seen, flushes);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("timeout: %0d outputs still pending", conv_expected.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
